// File: sv/nsfp_pkg.sv
// Shared types, constants and lookup functions of the NMEA sentence field parser.
`default_nettype none
package nsfp_pkg;

    localparam logic [47:0] MAG_NEG = 48'h8000_0000_0000;
    localparam logic [47:0] MAG_POS = 48'h7FFF_FFFF_FFFF;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [2:0] SEL_GGA = 3'd0;
    localparam logic [2:0] SEL_GSA = 3'd1;
    localparam logic [2:0] SEL_GSV = 3'd2;
    localparam logic [2:0] SEL_GLL = 3'd3;
    localparam logic [2:0] SEL_RMC = 3'd4;
    localparam logic [2:0] SEL_VTG = 3'd5;
    localparam logic [2:0] SEL_ZDA = 3'd6;
    localparam logic [2:0] SEL_NONE = 3'd7;

    localparam logic [2:0] HDR_LEN = 3'd6;

    localparam logic [2:0] REG_SENTENCE_SELECT = 3'd0;

    // running number of the current field
    typedef struct packed {
        logic [47:0] accum;     // value already scaled, clamped at MAG_NEG
        logic [2:0]  seen;      // fraction digits taken
        logic        neg;
        logic        point;
        logic        stopped;
        logic        started;
    } t_num;

    function automatic logic [23:0] pow10(input logic [2:0] j);
        logic [23:0] p;
        case (j)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] sel, input logic [2:0] pos);
        logic [47:0] s;
        logic [7:0]  c;
        case (sel)
            SEL_GGA: s = "$GPGGA";
            SEL_GSA: s = "$GPGSA";
            SEL_GSV: s = "$GPGSV";
            SEL_GLL: s = "$GPGLL";
            SEL_RMC: s = "$GPRMC";
            SEL_VTG: s = "$GPVTG";
            SEL_ZDA: s = "$GPZDA";
            default: s = 48'd0;
        endcase
        case (pos)
            3'd0:    c = s[47:40];
            3'd1:    c = s[39:32];
            3'd2:    c = s[31:24];
            3'd3:    c = s[23:16];
            3'd4:    c = s[15:8];
            3'd5:    c = s[7:0];
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] field_lim(input logic [2:0] sel);
        logic [4:0] l;
        case (sel)
            SEL_GGA: l = 5'd14;
            SEL_GSA: l = 5'd17;
            SEL_GSV: l = 5'd19;
            SEL_GLL: l = 5'd6;
            SEL_RMC: l = 5'd11;
            SEL_VTG: l = 5'd8;
            SEL_ZDA: l = 5'd6;
            default: l = 5'd0;
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

// File: sv/nsfp_byte_if.sv
// Input channel: one stream byte per beat.
`default_nettype none
interface nsfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: sv/nsfp_field_if.sv
// Output channel: one parsed field per beat.
`default_nettype none
interface nsfp_field_if;
    logic              valid;
    logic              ready;
    logic [4:0]        field_index;
    logic signed [47:0] field_value;
    logic [7:0]        first_char;
    logic              last_field;
    logic              parse_error;

    modport source (output valid, output field_index, output field_value,
                    output first_char, output last_field, output parse_error,
                    input ready);
    modport sink   (input valid, input field_index, input field_value,
                    input first_char, input last_field, input parse_error,
                    output ready);
endinterface
`default_nettype wire

// File: sv/nsfp_number.sv
// Next-state logic of the per-field decimal number scanner.
`default_nettype none
module nsfp_number #(
    parameter int FRAC_DIGITS = 5
) (
    input  wire logic [7:0]     i_char,
    input  wire nsfp_pkg::t_num i_cur,
    output nsfp_pkg::t_num      o_nxt
);

    logic        w_digit;
    logic        w_blank;
    logic [3:0]  w_d;
    logic        w_frac_ok;
    logic [2:0]  w_pow_idx;
    logic [27:0] w_term;
    logic [51:0] w_base;
    logic [51:0] w_sum;
    logic [47:0] w_acc_new;

    assign w_digit = (i_char >= nsfp_pkg::CH_ZERO) && (i_char <= nsfp_pkg::CH_NINE);
    assign w_blank = (i_char == nsfp_pkg::CH_SPACE) || (i_char == nsfp_pkg::CH_TAB) ||
                     (i_char == nsfp_pkg::CH_VT) || (i_char == nsfp_pkg::CH_FF) ||
                     (i_char == nsfp_pkg::CH_CR);
    assign w_d       = i_char[3:0];
    assign w_frac_ok = {1'b0, i_cur.seen} < 4'(FRAC_DIGITS);

    // integer digit: 10*acc + d*10^F ; fraction digit: acc + d*10^(F-1-seen)
    assign w_pow_idx = i_cur.point ? 3'(FRAC_DIGITS - 1 - int'(i_cur.seen))
                                   : 3'(FRAC_DIGITS);
    assign w_term    = 28'(w_d) * 28'(nsfp_pkg::pow10(w_pow_idx));
    assign w_base    = i_cur.point ? {4'd0, i_cur.accum}
                                   : ({4'd0, i_cur.accum} << 3) + ({4'd0, i_cur.accum} << 1);
    assign w_sum     = w_base + {24'd0, w_term};
    assign w_acc_new = (w_sum > {4'd0, nsfp_pkg::MAG_NEG}) ? nsfp_pkg::MAG_NEG : w_sum[47:0];

    always_comb begin
        o_nxt = i_cur;
        if (!i_cur.stopped) begin
            if (w_digit) begin
                o_nxt.started = 1'b1;
                if (!i_cur.point) begin
                    o_nxt.accum = w_acc_new;
                end else if (w_frac_ok) begin
                    o_nxt.accum = w_acc_new;
                    o_nxt.seen  = i_cur.seen + 3'd1;
                end
            end else if (i_char == nsfp_pkg::CH_DOT) begin
                if (i_cur.point) begin
                    o_nxt.stopped = 1'b1;
                end else begin
                    o_nxt.point   = 1'b1;
                    o_nxt.started = 1'b1;
                end
            end else if ((i_char == nsfp_pkg::CH_PLUS) || (i_char == nsfp_pkg::CH_MINUS)) begin
                if (i_cur.started) begin
                    o_nxt.stopped = 1'b1;
                end else begin
                    o_nxt.started = 1'b1;
                    o_nxt.neg     = (i_char == nsfp_pkg::CH_MINUS);
                end
            end else if (w_blank) begin
                if (i_cur.started) begin
                    o_nxt.stopped = 1'b1;
                end
            end else begin
                o_nxt.stopped = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/nmea_sentence_field_parser.sv
// Top level of the NMEA sentence field parser with its configuration port.
// A result is registered in the output register at the edge that accepts its byte.
// Throughput: one byte per cycle while the output drains; a waiting result stalls the
// input, since a byte may only enter when the output register is empty or leaves.
// Reset (synchronous, active low) clears the parser state, the output valid and
// sentence_select, which returns to GGA.
`default_nettype none
module nmea_sentence_field_parser #(
    parameter int MAX_FIELDS  = 19,
    parameter int FRAC_DIGITS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    nsfp_byte_if.sink        i_byte,
    nsfp_field_if.source     o_field,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'b001,
        PH_SKIP  = 3'b010,
        PH_FIELD = 3'b100
    } t_phase;

    localparam nsfp_pkg::t_num NUM_CLEAR = '{accum: 48'd0, seen: 3'd0, neg: 1'b0,
                                             point: 1'b0, stopped: 1'b0, started: 1'b0};

    localparam logic REG_IDX0 = nsfp_pkg::REG_SENTENCE_SELECT[0];

    logic [2:0]      r_sel;
    t_phase          r_phase,  n_phase;
    logic [2:0]      r_hpos,   n_hpos;
    logic [4:0]      r_fcount, n_fcount;
    nsfp_pkg::t_num  r_num,    n_num;
    logic [7:0]      r_first,  n_first;
    logic            r_empty,  n_empty;

    logic            r_out_valid;
    logic [4:0]      r_out_index;
    logic [47:0]     r_out_value;
    logic [7:0]      r_out_first;
    logic            r_out_last;
    logic            r_out_err;

    logic            n_res_valid;
    logic [4:0]      n_res_index;
    logic [47:0]     n_res_value;
    logic [7:0]      n_res_first;
    logic            n_res_last;
    logic            n_res_err;

    logic            w_accept;
    logic            w_cfg_wr;
    logic [7:0]      c;
    nsfp_pkg::t_num  w_num_fed;
    logic [4:0]      w_lim_raw;
    logic [5:0]      w_limit;
    logic [47:0]     w_value;
    logic            w_abort;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_IDX0) ? {29'd0, r_sel} : 32'd0;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign i_byte.ready = !r_out_valid || o_field.ready;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign c            = i_byte.in_byte;

    assign w_lim_raw = nsfp_pkg::field_lim(r_sel);
    assign w_limit   = ({1'b0, w_lim_raw} > 6'(MAX_FIELDS)) ? 6'(MAX_FIELDS)
                                                             : {1'b0, w_lim_raw};

    assign w_value = r_num.neg ? (~r_num.accum + 48'd1)
                               : ((r_num.accum > nsfp_pkg::MAG_POS) ? nsfp_pkg::MAG_POS
                                                                    : r_num.accum);

    assign w_abort = (c == nsfp_pkg::CH_DOLLAR) || (c == nsfp_pkg::CH_NL) ||
                     (c == nsfp_pkg::CH_NUL) ||
                     ((r_phase == PH_SKIP) && (c == nsfp_pkg::CH_STAR));

    nsfp_number #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_number (
        .i_char (c),
        .i_cur  (r_num),
        .o_nxt  (w_num_fed)
    );

    always_comb begin
        n_phase     = r_phase;
        n_hpos      = r_hpos;
        n_fcount    = r_fcount;
        n_num       = r_num;
        n_first     = r_first;
        n_empty     = r_empty;
        n_res_valid = 1'b0;
        n_res_index = r_fcount;
        n_res_value = 48'd0;
        n_res_first = 8'd0;
        n_res_last  = 1'b0;
        n_res_err   = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if ((r_sel != nsfp_pkg::SEL_NONE) && (r_hpos < nsfp_pkg::HDR_LEN) &&
                    (c == nsfp_pkg::hdr_char(r_sel, r_hpos))) begin
                    if (r_hpos + 3'd1 == nsfp_pkg::HDR_LEN) begin
                        n_phase = PH_SKIP;
                        n_hpos  = 3'd0;
                    end else begin
                        n_hpos = r_hpos + 3'd1;
                    end
                end else begin
                    n_hpos = (c == nsfp_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
                end
            end
            PH_SKIP, PH_FIELD: begin
                if (w_abort) begin
                    n_res_valid = 1'b1;
                    n_res_index = (r_phase == PH_SKIP) ? 5'd0 : r_fcount;
                    n_res_err   = 1'b1;
                    n_phase     = PH_HUNT;
                    n_fcount    = 5'd0;
                    n_hpos      = (c == nsfp_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
                    n_num       = NUM_CLEAR;
                    n_first     = 8'd0;
                    n_empty     = 1'b1;
                end else if (r_phase == PH_SKIP) begin
                    if (c == nsfp_pkg::CH_COMMA) begin
                        n_phase  = PH_FIELD;
                        n_fcount = 5'd0;
                        n_num    = NUM_CLEAR;
                        n_first  = 8'd0;
                        n_empty  = 1'b1;
                    end
                end else if ((c == nsfp_pkg::CH_COMMA) || (c == nsfp_pkg::CH_STAR)) begin
                    n_res_valid = 1'b1;
                    n_res_value = w_value;
                    n_res_first = r_empty ? 8'd0 : r_first;
                    n_res_last  = (c == nsfp_pkg::CH_STAR) ||
                                  (({1'b0, r_fcount} + 6'd1) >= w_limit);
                    n_num       = NUM_CLEAR;
                    n_first     = 8'd0;
                    n_empty     = 1'b1;
                    if (n_res_last) begin
                        n_phase  = PH_HUNT;
                        n_fcount = 5'd0;
                        n_hpos   = 3'd0;
                    end else begin
                        n_fcount = r_fcount + 5'd1;
                    end
                end else begin
                    if (r_empty) begin
                        n_first = c;
                        n_empty = 1'b0;
                    end
                    n_num = w_num_fed;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_hpos  = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel    <= nsfp_pkg::SEL_GGA;
            r_phase  <= PH_HUNT;
            r_hpos   <= 3'd0;
            r_fcount <= 5'd0;
            r_num    <= NUM_CLEAR;
            r_first  <= 8'd0;
            r_empty  <= 1'b1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_IDX0) begin
                r_sel    <= pwdata[2:0];
                r_phase  <= PH_HUNT;
                r_hpos   <= 3'd0;
                r_fcount <= 5'd0;
                r_num    <= NUM_CLEAR;
                r_first  <= 8'd0;
                r_empty  <= 1'b1;
            end
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_hpos   <= n_hpos;
            r_fcount <= n_fcount;
            r_num    <= n_num;
            r_first  <= n_first;
            r_empty  <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= n_res_valid;
        end else if (o_field.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_res_valid) begin
            r_out_index <= n_res_index;
            r_out_value <= n_res_value;
            r_out_first <= n_res_first;
            r_out_last  <= n_res_last;
            r_out_err   <= n_res_err;
        end
    end

    assign o_field.valid       = r_out_valid;
    assign o_field.field_index = r_out_index;
    assign o_field.field_value = r_out_value;
    assign o_field.first_char  = r_out_first;
    assign o_field.last_field  = r_out_last;
    assign o_field.parse_error = r_out_err;

    // an error beat never also closes a sentence normally
    a_err_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_err && r_out_last))
        else $error("error beat flagged as last field");

    // field index stays below the field limit cap
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_err) |-> ({1'b0, r_out_index} < 6'(MAX_FIELDS)))
        else $error("field index beyond limit");

    // a select write drops any sentence in progress
    a_cfg_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && (paddr[2] == REG_IDX0)) |=> (r_phase == PH_HUNT) && (r_fcount == 5'd0))
        else $error("select write did not restart hunting");

    // a result that waits is not overwritten by a byte that gives none
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_field.ready) |-> !w_accept)
        else $error("byte accepted while result blocked");

endmodule
`default_nettype wire

// File: tb/nmea_sentence_field_parser_tb.sv
// Self-checking testbench of the NMEA sentence field parser: random sentences and a field predictor.
`default_nettype none
module nmea_sentence_field_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FIELDS  = 19;
    localparam int FRAC_DIGITS = 5;

    typedef enum logic [1:0] {PH_HUNT, PH_SKIP, PH_FIELDS} t_parse_phase;

    typedef struct {
        logic [4:0]  idx;
        logic [47:0] val;
        logic [7:0]  fc;
        logic        last;
        logic        err;
    } t_field;

    string sentence_hdr[7] = '{"$GPGGA", "$GPGSA", "$GPGSV", "$GPGLL",
                               "$GPRMC", "$GPVTG", "$GPZDA"};
    int    sentence_lim[8] = '{14, 17, 19, 6, 11, 8, 6, 0};

    class field_scoreboard;
        logic [2:0]   sel;
        t_parse_phase ph;
        logic [2:0]   hpos;
        logic [4:0]   fcount;
        logic [63:0]  acc;
        logic [2:0]   frac;
        bit           neg, pt, stopped, started, empty;
        logic [7:0]   first;
        t_field       pending[$];
        int           errors;

        function new();
            errors = 0;
            set_select(nsfp_pkg::SEL_GGA);
        endfunction

        function void clear_field();
            acc = 0; frac = 0; neg = 0; pt = 0; stopped = 0; started = 0;
            first = 0; empty = 1;
        endfunction

        function void set_select(logic [2:0] v);
            sel = v; ph = PH_HUNT; hpos = 0; fcount = 0;
            clear_field();
        endfunction

        function logic [63:0] mac10(logic [63:0] a, int unsigned d);
            if (a > (64'(nsfp_pkg::MAG_NEG) - 64'(d)) / 10) return 64'(nsfp_pkg::MAG_NEG);
            return a * 10 + 64'(d);
        endfunction

        function void feed_number(logic [7:0] c);
            if (stopped) return;
            if (c >= nsfp_pkg::CH_ZERO && c <= nsfp_pkg::CH_NINE) begin
                started = 1;
                if (!pt) begin
                    acc = mac10(acc, c - nsfp_pkg::CH_ZERO);
                end else if (frac < FRAC_DIGITS) begin
                    acc = mac10(acc, c - nsfp_pkg::CH_ZERO);
                    frac++;
                end
            end else if (c == nsfp_pkg::CH_DOT) begin
                if (pt) stopped = 1;
                else begin
                    pt = 1; started = 1;
                end
            end else if (c == nsfp_pkg::CH_PLUS || c == nsfp_pkg::CH_MINUS) begin
                if (started) stopped = 1;
                else begin
                    started = 1; neg = (c == nsfp_pkg::CH_MINUS);
                end
            end else if (c == nsfp_pkg::CH_SPACE || c == nsfp_pkg::CH_TAB ||
                         c == nsfp_pkg::CH_VT || c == nsfp_pkg::CH_FF ||
                         c == nsfp_pkg::CH_CR) begin
                if (started) stopped = 1;
            end else begin
                stopped = 1;
            end
        endfunction

        function logic [47:0] scaled_value();
            logic [63:0] m;
            m = acc;
            for (int i = frac; i < FRAC_DIGITS; i++) m = mac10(m, 0);
            if (neg) return 48'(~m + 1);
            return (m > 64'(nsfp_pkg::MAG_POS)) ? nsfp_pkg::MAG_POS : m[47:0];
        endfunction

        function void note_byte(logic [7:0] c);
            t_field f;
            int     lim;
            if (ph == PH_HUNT) begin
                if (sel < 7 && hpos < 6 && c == sentence_hdr[sel][hpos]) begin
                    hpos++;
                    if (hpos == 6) begin
                        ph = PH_SKIP; hpos = 0;
                    end
                end else begin
                    hpos = (c == nsfp_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
                end
                return;
            end
            if (c == nsfp_pkg::CH_DOLLAR || c == nsfp_pkg::CH_NL || c == nsfp_pkg::CH_NUL ||
                (ph == PH_SKIP && c == nsfp_pkg::CH_STAR)) begin
                f.idx = (ph == PH_SKIP) ? 5'd0 : fcount;
                f.val = 0; f.fc = 0; f.last = 0; f.err = 1;
                pending.push_back(f);
                ph = PH_HUNT; fcount = 0;
                hpos = (c == nsfp_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
                clear_field();
                return;
            end
            if (ph == PH_SKIP) begin
                if (c == nsfp_pkg::CH_COMMA) begin
                    ph = PH_FIELDS; fcount = 0; clear_field();
                end
                return;
            end
            if (c == nsfp_pkg::CH_COMMA || c == nsfp_pkg::CH_STAR) begin
                lim = sentence_lim[sel];
                if (lim > MAX_FIELDS) lim = MAX_FIELDS;
                f.idx  = fcount;
                f.val  = scaled_value();
                f.fc   = empty ? 8'd0 : first;
                f.last = (c == nsfp_pkg::CH_STAR || int'(fcount) + 1 >= lim);
                f.err  = 0;
                pending.push_back(f);
                clear_field();
                if (f.last) begin
                    ph = PH_HUNT; fcount = 0; hpos = 0;
                end else begin
                    fcount = fcount + 1;
                end
                return;
            end
            if (empty) begin
                first = c; empty = 0;
            end
            feed_number(c);
        endfunction

        function void check_field(t_field act);
            t_field e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected field: idx=%0d val=%0d fc=%02h last=%0b err=%0b",
                         $time, act.idx, $signed(act.val), act.fc, act.last, act.err);
                return;
            end
            e = pending.pop_front();
            if (e.idx !== act.idx || e.val !== act.val || e.fc !== act.fc ||
                e.last !== act.last || e.err !== act.err) begin
                errors++;
                $display("%0t mismatch: expected idx=%0d val=%0d fc=%02h last=%0b err=%0b",
                         $time, e.idx, $signed(e.val), e.fc, e.last, e.err);
                $display("%0t            actual idx=%0d val=%0d fc=%02h last=%0b err=%0b",
                         $time, act.idx, $signed(act.val), act.fc, act.last, act.err);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nsfp_byte_if  byte_ch();
    nsfp_field_if field_ch();

    nmea_sentence_field_parser #(
        .MAX_FIELDS (MAX_FIELDS),
        .FRAC_DIGITS(FRAC_DIGITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_byte (byte_ch),
        .o_field(field_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    field_scoreboard sb = new();

    int         send_idle = 0;
    int         recv_idle = 0;
    logic [7:0] stream[$];

    logic [2:0] sel_plan[12] = '{nsfp_pkg::SEL_GGA, nsfp_pkg::SEL_ZDA,
                                 nsfp_pkg::SEL_NONE, nsfp_pkg::SEL_GSV,
                                 nsfp_pkg::SEL_GSA, nsfp_pkg::SEL_GLL,
                                 nsfp_pkg::SEL_RMC, nsfp_pkg::SEL_VTG,
                                 nsfp_pkg::SEL_GSV, nsfp_pkg::SEL_GGA,
                                 nsfp_pkg::SEL_ZDA, nsfp_pkg::SEL_NONE};

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        field_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_field act;
        if (i_rst_n) begin
            if (field_ch.valid && field_ch.ready) begin
                act.idx  = field_ch.field_index;
                act.val  = field_ch.field_value;
                act.fc   = field_ch.first_char;
                act.last = field_ch.last_field;
                act.err  = field_ch.parse_error;
                sb.check_field(act);
            end
            if (byte_ch.valid && byte_ch.ready) sb.note_byte(byte_ch.in_byte);
        end
    end

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == nsfp_pkg::CH_COMMA || c == nsfp_pkg::CH_STAR ||
               c == nsfp_pkg::CH_DOLLAR || c == nsfp_pkg::CH_NL || c == nsfp_pkg::CH_NUL);
        return c;
    endfunction

    function automatic logic [7:0] digit();
        return nsfp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] blank();
        case ($urandom_range(0, 4))
            0: return nsfp_pkg::CH_SPACE;
            1: return nsfp_pkg::CH_TAB;
            2: return nsfp_pkg::CH_VT;
            3: return nsfp_pkg::CH_FF;
            default: return nsfp_pkg::CH_CR;
        endcase
    endfunction

    function automatic void push_sign();
        case ($urandom_range(0, 2))
            0: stream.push_back(nsfp_pkg::CH_MINUS);
            1: stream.push_back(nsfp_pkg::CH_PLUS);
            default: ;
        endcase
    endfunction

    function automatic void push_digits(int n);
        for (int i = 0; i < n; i++) stream.push_back(digit());
    endfunction

    function automatic void add_field();
        string letters;
        letters = "NSEWAVMKT";
        case ($urandom_range(0, 9))
            0: ;
            1: stream.push_back(letters[$urandom_range(0, letters.len() - 1)]);
            2: begin
                repeat ($urandom_range(0, 2)) stream.push_back(blank());
                push_sign();
                push_digits($urandom_range(1, 6));
            end
            3: begin
                push_sign();
                push_digits($urandom_range(0, 4));
                stream.push_back(nsfp_pkg::CH_DOT);
                push_digits($urandom_range(0, 8));
            end
            4: begin
                push_sign();
                push_digits($urandom_range(10, 20));
                if ($urandom_range(0, 1)) begin
                    stream.push_back(nsfp_pkg::CH_DOT);
                    push_digits($urandom_range(0, 7));
                end
            end
            5: begin
                push_sign();
                push_digits($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0: stream.push_back(nsfp_pkg::CH_DOT);
                    1: stream.push_back($urandom_range(0, 1) ? nsfp_pkg::CH_PLUS
                                                             : nsfp_pkg::CH_MINUS);
                    2: stream.push_back(blank());
                    default: stream.push_back(plain_byte());
                endcase
                if ($urandom_range(0, 1)) stream.push_back(nsfp_pkg::CH_DOT);
                push_digits($urandom_range(0, 3));
            end
            6: repeat ($urandom_range(1, 4)) stream.push_back(plain_byte());
            7: begin
                repeat ($urandom_range(1, 3)) stream.push_back(blank());
                push_digits($urandom_range(1, 3));
                repeat ($urandom_range(1, 2)) stream.push_back(plain_byte());
            end
            8: begin
                push_sign();
                if ($urandom_range(0, 1)) stream.push_back(nsfp_pkg::CH_DOT);
                if ($urandom_range(0, 1)) stream.push_back(blank());
            end
            default: begin
                push_digits($urandom_range(1, 5));
                stream.push_back(nsfp_pkg::CH_DOT);
                push_digits($urandom_range(1, 6));
            end
        endcase
    endfunction

    function automatic void add_sentence(logic [2:0] sel);
        int    kind, nf, lim;
        string hdr, hex;
        hex = "0123456789ABCDEF";
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) stream.push_back(8'($urandom_range(0, 255)));
        if (sel < 7 && $urandom_range(0, 99) < 85) hdr = sentence_hdr[sel];
        else hdr = sentence_hdr[$urandom_range(0, 6)];
        if ($urandom_range(0, 9) == 0) hdr[$urandom_range(1, 5)] = plain_byte();
        push_str(hdr);
        if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) stream.push_back(plain_byte());
        if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 3))
                0: stream.push_back(nsfp_pkg::CH_STAR);
                1: stream.push_back(nsfp_pkg::CH_DOLLAR);
                2: stream.push_back(nsfp_pkg::CH_NL);
                default: stream.push_back(nsfp_pkg::CH_NUL);
            endcase
            return;
        end
        stream.push_back(nsfp_pkg::CH_COMMA);
        lim = (sel < 7) ? sentence_lim[sel] : 8;
        if ($urandom_range(0, 9) < 3) nf = $urandom_range(lim - 1, lim + 1);
        else nf = $urandom_range(0, lim);
        for (int i = 0; i < nf; i++) begin
            add_field();
            stream.push_back(nsfp_pkg::CH_COMMA);
        end
        add_field();
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            stream.push_back(nsfp_pkg::CH_STAR);
            stream.push_back(hex[$urandom_range(0, 15)]);
            stream.push_back(hex[$urandom_range(0, 15)]);
            stream.push_back(nsfp_pkg::CH_CR);
            stream.push_back(nsfp_pkg::CH_NL);
        end else if (kind < 85) begin
            case ($urandom_range(0, 2))
                0: stream.push_back(nsfp_pkg::CH_DOLLAR);
                1: stream.push_back(nsfp_pkg::CH_NL);
                default: stream.push_back(nsfp_pkg::CH_NUL);
            endcase
        end
    endfunction

    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= c;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_stream();
        while (stream.size() != 0) send_byte(stream.pop_front());
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_select(input logic [2:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(nsfp_pkg::REG_SENTENCE_SELECT * 4);
        pwdata  <= {29'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_select(v);
    endtask

    initial begin
        #200000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int n;
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= 8'd0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= 3'd0;
        pwdata          <= 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // negative with dropped fraction digit, empty field, high byte with '*', star in skip
        push_str("$GPGGA,-1.234567,,");
        stream.push_back(8'hFF);
        push_str("*$GPGGA*");
        send_stream();

        for (int m = 0; m < 3; m++) begin
            case (m)
                0: begin send_idle = 29; recv_idle = 71; end
                1: begin send_idle = 71; recv_idle = 29; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int p = 0; p < 4; p++) begin
                drain();
                write_select(sel_plan[m * 4 + p]);
                n = 0;
                while (n < 110) begin
                    add_sentence(sel_plan[m * 4 + p]);
                    n += stream.size();
                    send_stream();
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
